[src/epri_pkg.sv]
// Shared constants and helpers of the epipolar residual inlier test.
// Used by the core, its port checker and the bench; depends on nothing else.
`default_nettype none

package epri_pkg;

    // Default sizes of the coordinate and coefficient fields.
    localparam int COORD_BITS_DEF = 16;
    localparam int COEF_BITS_DEF  = 21;

    // Configuration register file.
    localparam int CFG_DATA_BITS = 63;
    localparam int CFG_ADDR_BITS = 2;
    localparam int LIMIT_BITS    = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ROW0  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ROW1  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ROW2  = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LIMIT = 2'd3;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1296;

    // Result field: a Q16.8 value, also the width of each quotient.
    localparam int RES_BITS = 24;
    localparam logic [RES_BITS-1:0] RES_MAX = 24'hFFFFFF;

    // Guard term of the denominators, 1e-8 in Q.40.
    localparam longint unsigned EPS_Q40 = 64'd10995;

    // Sideband bit positions of the result channel.
    localparam int OUT_INLIER_BIT = 0;
    localparam int OUT_SAT_BIT    = 1;
    localparam int OUT_USER_BITS  = 2;

    // Input stream data width: four coordinates padded to whole bytes.
    function automatic int in_tdata_bits(input int coord_bits);
        return ((4 * coord_bits + 7) >> 3) << 3;
    endfunction

endpackage

`default_nettype wire

[src/epipolar_residual_inlier_test_core.sv]
// Symmetric epipolar residual and inlier test, fully pipelined core.
// Depends on epri_pkg for sizes, register codes and constants.
`default_nettype none

// Usage
// The input stream carries one point match per item: s_tdata holds the left
// and right pixel coordinates and s_tuser holds the keep bit of the robust
// estimator. The result stream returns one item per match: m_tdata holds the
// residual and m_tuser holds the inlier and saturation flags.
// The user writes the fundamental matrix rows and the residual limit through
// the plain cfg port while no match is in flight; the block does not enforce it.
// Throughput is one item per cycle while the result stream is not stalled. An
// accepted item passes five arithmetic stages, one stage per quotient bit plus
// one range check in the two restoring dividers, and the output register.
// Reset clears every valid bit, the matrix rows to zero and the limit to
// 5.0625; payload registers are not reset.
// When the receiver stalls, the output register holds its item and a skid
// register catches the one item still leaving the pipeline; s_tready then
// drops and the whole pipeline freezes until the output register drains,
// so nothing is lost or repeated.

module epipolar_residual_inlier_test_core #(
    parameter int COORD_BITS = epri_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = epri_pkg::COEF_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // Fields from bit 0 up: left_x, left_y, right_x, right_y, zero fill.
    input  wire logic [epri_pkg::in_tdata_bits(COORD_BITS)-1:0] s_tdata,
    // Fields from bit 0 up: ransac_keep.
    input  wire logic [0:0]                               s_tuser,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // Fields from bit 0 up: residual.
    output logic [epri_pkg::RES_BITS-1:0]                 m_tdata,
    // Fields from bit 0 up: is_inlier, residual_saturated.
    output logic [epri_pkg::OUT_USER_BITS-1:0]            m_tuser,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    input  wire logic                                     cfg_we,
    input  wire logic [epri_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
    input  wire logic [epri_pkg::CFG_DATA_BITS-1:0]       cfg_wdata
);

    localparam int C    = COORD_BITS;
    localparam int K    = COEF_BITS;
    localparam int QB   = epri_pkg::RES_BITS;
    localparam int AW   = K + C + 3;          // epipolar line terms, Q.20
    localparam int PW   = AW + C + 3;         // point residual pt, Q.24
    localparam int AL   = AW / 2;
    localparam int AH   = AW - AL;
    localparam int DW   = 2 * AW + 2;         // denominators, Q.40
    localparam int PL   = PW / 2;
    localparam int PH   = PW - PL;
    localparam int SW   = 2 * PW;             // pt squared, Q.48
    localparam int NDIV = QB + 1;             // range check plus one stage per bit
    localparam int NV   = 4 + NDIV + 1;       // valid bits: S1..S4 and divider chain

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [epri_pkg::CFG_DATA_BITS-1:0] row0_reg, row1_reg, row2_reg;
    logic [epri_pkg::LIMIT_BITS-1:0]    limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg  <= '0;
            row1_reg  <= '0;
            row2_reg  <= '0;
            limit_reg <= epri_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                epri_pkg::REG_ROW0:  row0_reg  <= cfg_wdata;
                epri_pkg::REG_ROW1:  row1_reg  <= cfg_wdata;
                epri_pkg::REG_ROW2:  row2_reg  <= cfg_wdata;
                epri_pkg::REG_LIMIT: limit_reg <= cfg_wdata[epri_pkg::LIMIT_BITS-1:0];
            endcase
        end
    end

    // Matrix coefficients, f[3*row + column].
    logic signed [K-1:0] f [9];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            f[c]     = row0_reg[K*c +: K];
            f[3 + c] = row1_reg[K*c +: K];
            f[6 + c] = row2_reg[K*c +: K];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together and freeze while the skid
    // register below holds an item.
    // ------------------------------------------------------------------
    logic          skid_v_reg;
    logic          en;
    logic [NV-1:0] vld_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NV-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: epipolar lines a = F*l and b = F^T*r (first two terms of b).
    // ------------------------------------------------------------------
    logic [C-1:0] lx, ly, rx, ry;
    assign lx = s_tdata[0     +: C];
    assign ly = s_tdata[C     +: C];
    assign rx = s_tdata[2 * C +: C];
    assign ry = s_tdata[3 * C +: C];

    logic signed [C:0] lxs, lys, rxs, rys, ws;
    assign lxs = $signed({1'b0, lx});
    assign lys = $signed({1'b0, ly});
    assign rxs = $signed({1'b0, rx});
    assign rys = $signed({1'b0, ry});
    assign ws  = $signed({1'b0, C'(16)});     // w = 1 at four fraction bits

    logic signed [AW-1:0] a_next [3];
    logic signed [AW-1:0] b_next [2];

    for (genvar i = 0; i < 3; i++) begin : g_a
        logic signed [K+C:0] p0, p1, p2;
        assign p0 = f[3*i]     * lxs;
        assign p1 = f[3*i + 1] * lys;
        assign p2 = f[3*i + 2] * ws;
        assign a_next[i] = AW'(p0) + AW'(p1) + AW'(p2);
    end

    for (genvar i = 0; i < 2; i++) begin : g_b
        logic signed [K+C:0] p0, p1, p2;
        assign p0 = f[i]     * rxs;
        assign p1 = f[3 + i] * rys;
        assign p2 = f[6 + i] * ws;
        assign b_next[i] = AW'(p0) + AW'(p1) + AW'(p2);
    end

    logic signed [AW-1:0] s1_a_reg [3];
    logic signed [AW-1:0] s1_b_reg [2];
    logic [C-1:0]         s1_rx_reg, s1_ry_reg;
    logic                 s1_keep_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_a_reg    <= a_next;
            s1_b_reg    <= b_next;
            s1_rx_reg   <= rx;
            s1_ry_reg   <= ry;
            s1_keep_reg <= s_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pt = r . (F*l), and the split squares of the line terms.
    // ------------------------------------------------------------------
    logic signed [AW+C:0] ptp0, ptp1, ptp2;
    logic signed [PW-1:0] pt_next;
    assign ptp0 = s1_a_reg[0] * $signed({1'b0, s1_rx_reg});
    assign ptp1 = s1_a_reg[1] * $signed({1'b0, s1_ry_reg});
    assign ptp2 = s1_a_reg[2] * ws;
    assign pt_next = PW'(ptp0) + PW'(ptp1) + PW'(ptp2);

    // Magnitudes in the order a0, a1, b0, b1.
    logic signed [AW-1:0] line_v [4];
    assign line_v[0] = s1_a_reg[0];
    assign line_v[1] = s1_a_reg[1];
    assign line_v[2] = s1_b_reg[0];
    assign line_v[3] = s1_b_reg[1];

    logic [2*AH-1:0]  lhh_next [4];
    logic [AW-1:0]    lhl_next [4];
    logic [2*AL-1:0]  lll_next [4];

    for (genvar k = 0; k < 4; k++) begin : g_lsq
        logic [AW-1:0] m;
        assign m = line_v[k][AW-1] ? AW'(-line_v[k]) : AW'(line_v[k]);
        assign lhh_next[k] = m[AW-1:AL] * m[AW-1:AL];
        assign lhl_next[k] = m[AW-1:AL] * m[AL-1:0];
        assign lll_next[k] = m[AL-1:0]  * m[AL-1:0];
    end

    logic signed [PW-1:0] s2_pt_reg;
    logic [2*AH-1:0]      s2_hh_reg [4];
    logic [AW-1:0]        s2_hl_reg [4];
    logic [2*AL-1:0]      s2_ll_reg [4];
    logic                 s2_keep_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_pt_reg   <= pt_next;
            s2_hh_reg   <= lhh_next;
            s2_hl_reg   <= lhl_next;
            s2_ll_reg   <= lll_next;
            s2_keep_reg <= s1_keep_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: |pt| and the two denominators x^2 + y^2 + eps.
    // ------------------------------------------------------------------
    logic [DW-1:0] sq_line [4];
    for (genvar k = 0; k < 4; k++) begin : g_lsum
        assign sq_line[k] = (DW'(s2_hh_reg[k]) << (2 * AL))
                          + (DW'(s2_hl_reg[k]) << (AL + 1))
                          + DW'(s2_ll_reg[k]);
    end

    logic [DW-1:0] da_next, db_next;
    logic [PW-1:0] ptm_next;
    assign da_next  = sq_line[0] + sq_line[1] + DW'(epri_pkg::EPS_Q40);
    assign db_next  = sq_line[2] + sq_line[3] + DW'(epri_pkg::EPS_Q40);
    assign ptm_next = s2_pt_reg[PW-1] ? PW'(-s2_pt_reg) : PW'(s2_pt_reg);

    logic [PW-1:0] s3_ptm_reg;
    logic [DW-1:0] s3_da_reg, s3_db_reg;
    logic          s3_keep_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_ptm_reg  <= ptm_next;
            s3_da_reg   <= da_next;
            s3_db_reg   <= db_next;
            s3_keep_reg <= s2_keep_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: split partial products of pt squared.
    // ------------------------------------------------------------------
    logic [2*PH-1:0] s4_hh_reg;
    logic [PW-1:0]   s4_hl_reg;
    logic [2*PL-1:0] s4_ll_reg;
    logic [DW-1:0]   s4_da_reg, s4_db_reg;
    logic            s4_keep_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_hh_reg   <= s3_ptm_reg[PW-1:PL] * s3_ptm_reg[PW-1:PL];
            s4_hl_reg   <= s3_ptm_reg[PW-1:PL] * s3_ptm_reg[PL-1:0];
            s4_ll_reg   <= s3_ptm_reg[PL-1:0]  * s3_ptm_reg[PL-1:0];
            s4_da_reg   <= s3_da_reg;
            s4_db_reg   <= s3_db_reg;
            s4_keep_reg <= s3_keep_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain. Entry 0 holds pt squared as the starting remainder of
    // both quotients. Entry j (1..NDIV) tries den << (QB+1-j); the first one
    // is the range check, whose bit marks a quotient that reached 2^24 and
    // freezes it from then on.
    // ------------------------------------------------------------------
    logic [SW-1:0] rem_a_reg [0:NDIV];
    logic [SW-1:0] rem_b_reg [0:NDIV];
    logic [QB:0]   qa_reg    [0:NDIV];
    logic [QB:0]   qb_reg    [0:NDIV];
    logic [DW-1:0] den_a_reg [0:NDIV];
    logic [DW-1:0] den_b_reg [0:NDIV];
    logic          keep_reg  [0:NDIV];

    logic [SW-1:0] sq_next;
    assign sq_next = (SW'(s4_hh_reg) << (2 * PL))
                   + (SW'(s4_hl_reg) << (PL + 1))
                   + SW'(s4_ll_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_a_reg[0] <= sq_next;
            rem_b_reg[0] <= sq_next;
            qa_reg[0]    <= '0;
            qb_reg[0]    <= '0;
            den_a_reg[0] <= s4_da_reg;
            den_b_reg[0] <= s4_db_reg;
            keep_reg[0]  <= s4_keep_reg;
        end
    end

    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        localparam int SH = QB + 1 - j;
        logic [SW-1:0] ta, tb;
        logic          ga, gb;
        assign ta = SW'(den_a_reg[j-1]) << SH;
        assign tb = SW'(den_b_reg[j-1]) << SH;
        assign ga = !qa_reg[j-1][QB] && (rem_a_reg[j-1] >= ta);
        assign gb = !qb_reg[j-1][QB] && (rem_b_reg[j-1] >= tb);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a_reg[j] <= ga ? rem_a_reg[j-1] - ta : rem_a_reg[j-1];
                rem_b_reg[j] <= gb ? rem_b_reg[j-1] - tb : rem_b_reg[j-1];
                qa_reg[j]    <= qa_reg[j-1] | ((QB+1)'(ga) << SH);
                qb_reg[j]    <= qb_reg[j-1] | ((QB+1)'(gb) << SH);
                den_a_reg[j] <= den_a_reg[j-1];
                den_b_reg[j] <= den_b_reg[j-1];
                keep_reg[j]  <= keep_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final sum, saturation and limit test on the way to the output.
    // ------------------------------------------------------------------
    logic [QB+1:0]  sum;
    logic           sat_next;
    logic [QB-1:0]  res_next;
    logic           inl_next;
    logic           pipe_v;

    assign pipe_v   = vld_reg[NV-1];
    assign sum      = {1'b0, qa_reg[NDIV]} + {1'b0, qb_reg[NDIV]};
    assign sat_next = sum > (QB+2)'(epri_pkg::RES_MAX);
    assign res_next = sat_next ? epri_pkg::RES_MAX : sum[QB-1:0];
    assign inl_next = keep_reg[NDIV] && (res_next <= QB'(limit_reg));

    // ------------------------------------------------------------------
    // Output register with skid register.
    // ------------------------------------------------------------------
    logic                              m_tvalid_reg;
    logic [QB-1:0]                     out_res_reg, skid_res_reg;
    logic [epri_pkg::OUT_USER_BITS-1:0] out_user_reg, skid_user_reg;
    logic [epri_pkg::OUT_USER_BITS-1:0] user_next;
    logic                              out_load;

    always_comb begin
        user_next = '0;
        user_next[epri_pkg::OUT_INLIER_BIT] = inl_next;
        user_next[epri_pkg::OUT_SAT_BIT]    = sat_next;
    end

    assign out_load = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_v_reg   <= 1'b0;
        end else if (out_load) begin
            if (skid_v_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_v_reg   <= 1'b0;
            end else begin
                m_tvalid_reg <= pipe_v;
            end
        end else if (pipe_v && en) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_res_reg  <= skid_v_reg ? skid_res_reg  : res_next;
            out_user_reg <= skid_v_reg ? skid_user_reg : user_next;
        end else if (en) begin
            skid_res_reg  <= res_next;
            skid_user_reg <= user_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_res_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

[src/epri_checker.sv]
// Port-level checker for the epipolar residual inlier test core, with its bind.
// Depends on epri_pkg; binds to epipolar_residual_inlier_test_core.
`default_nettype none

module epri_checker (
    input wire logic                                     aclk,
    input wire logic                                     aresetn,
    input wire logic                                     s_tready,
    input wire logic [epri_pkg::RES_BITS-1:0]            m_tdata,
    input wire logic [epri_pkg::OUT_USER_BITS-1:0]       m_tuser,
    input wire logic                                     m_tvalid,
    input wire logic                                     m_tready
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // A saturated residual reads as the field maximum and is never an inlier.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[epri_pkg::OUT_SAT_BIT] |->
            !m_tuser[epri_pkg::OUT_INLIER_BIT] && (m_tdata == epri_pkg::RES_MAX))
        else $error("saturated residual malformed");

    // Reset empties the result side.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The input side only backs off after the result side was stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without a result stall");

endmodule

bind epipolar_residual_inlier_test_core epri_checker u_epri_checker (.*);

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench of the epipolar residual inlier test core.
// Drives point matches with random idling on both streams and compares every result
// item with a bit-exact residual predictor or typed verdict; uses epri_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    localparam int CB = epri_pkg::COORD_BITS_DEF;
    localparam int FB = epri_pkg::COEF_BITS_DEF;
    localparam int IN_BITS = epri_pkg::in_tdata_bits(CB);

    typedef logic signed [127:0] swide_t;
    typedef logic [255:0] uwide_t;

    typedef struct packed {
        logic [epri_pkg::RES_BITS-1:0] residual;
        logic                inlier;
        logic                sat;
    } verdict_t;

    typedef struct {
        logic [CB-1:0] lx, ly, rx, ry;
        logic          keep;
        bit            typed;
        verdict_t      want;
    } match_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_BITS-1:0]    s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [epri_pkg::RES_BITS-1:0]   m_tdata;
    logic [epri_pkg::OUT_USER_BITS-1:0] m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [epri_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [epri_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // Bench copy of the register file.
    logic [epri_pkg::CFG_DATA_BITS-1:0] row_reg [3];
    logic [epri_pkg::LIMIT_BITS-1:0]    limit_reg;

    verdict_t  verdict_q [$];
    int        errors = 0;
    int        accepted = 0;
    bit        typed_on = 1'b0;
    verdict_t  typed_want;
    bit        quiet = 1'b0;
    int        hold = 0;

    always #5 aclk = ~aclk;

    epipolar_residual_inlier_test_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Signed coefficient of matrix entry (row, col), sign-extended.
    function automatic swide_t coef_of(input int row, input int col);
        logic [FB-1:0] raw;
        raw = row_reg[row][FB*col +: FB];
        return swide_t'($signed(raw));
    endfunction

    // floor(num/den), clamped to 2^24 once the quotient reaches it.
    function automatic uwide_t clamp_div(input uwide_t num, input uwide_t den);
        if (num >= (den << epri_pkg::RES_BITS)) return uwide_t'(1) << epri_pkg::RES_BITS;
        return num / den;
    endfunction

    // Symmetric epipolar residual of one match under the current registers.
    function automatic verdict_t residual_of(input logic [CB-1:0] lx, ly, rx, ry,
                                             input logic keep);
        swide_t   f [9];
        swide_t   a [3];
        swide_t   b [3];
        swide_t   slx, sly, srx, sry, pt;
        uwide_t   pmag, sq, da, db, ma, sum;
        verdict_t v;
        slx = swide_t'({1'b0, lx});
        sly = swide_t'({1'b0, ly});
        srx = swide_t'({1'b0, rx});
        sry = swide_t'({1'b0, ry});
        for (int k = 0; k < 9; k++) f[k] = coef_of(k / 3, k % 3);
        for (int i = 0; i < 3; i++) begin
            a[i] = f[3*i] * slx + f[3*i+1] * sly + f[3*i+2] * 16;
            b[i] = f[i] * srx + f[3+i] * sry + f[6+i] * 16;
        end
        pt = srx * a[0] + sry * a[1] + a[2] * 16;
        pmag = uwide_t'(pt < 0 ? -pt : pt);
        sq = pmag * pmag;
        ma = uwide_t'(a[0] < 0 ? -a[0] : a[0]);
        da = ma * ma;
        ma = uwide_t'(a[1] < 0 ? -a[1] : a[1]);
        da = da + ma * ma + epri_pkg::EPS_Q40;
        ma = uwide_t'(b[0] < 0 ? -b[0] : b[0]);
        db = ma * ma;
        ma = uwide_t'(b[1] < 0 ? -b[1] : b[1]);
        db = db + ma * ma + epri_pkg::EPS_Q40;
        sum = clamp_div(sq, da) + clamp_div(sq, db);
        v.sat = (sum > uwide_t'(epri_pkg::RES_MAX));
        v.residual = v.sat ? epri_pkg::RES_MAX : sum[epri_pkg::RES_BITS-1:0];
        v.inlier = keep && (v.residual <= limit_reg);
        return v;
    endfunction

    // Input side: every accepted item queues its expected verdict.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (typed_on) verdict_q.insert(verdict_q.size(), typed_want);
            else verdict_q.insert(verdict_q.size(),
                                  residual_of(s_tdata[0 +: CB], s_tdata[CB +: CB],
                                              s_tdata[2*CB +: CB], s_tdata[3*CB +: CB],
                                              s_tuser[0]));
            accepted <= accepted + 1;
        end
    end

    // Result side: compare each accepted result item with the oldest verdict.
    always @(posedge aclk) begin
        verdict_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result item with nothing expected, got res=%h user=%b",
                         $realtime, m_tdata, m_tuser);
                errors++;
            end else begin
                w = verdict_q.pop_front();
                if (m_tdata !== w.residual) begin
                    $display("%0t: residual expected %h actual %h", $realtime,
                             w.residual, m_tdata);
                    errors++;
                end
                if (m_tuser[epri_pkg::OUT_INLIER_BIT] !== w.inlier) begin
                    $display("%0t: is_inlier expected %b actual %b", $realtime,
                             w.inlier, m_tuser[epri_pkg::OUT_INLIER_BIT]);
                    errors++;
                end
                if (m_tuser[epri_pkg::OUT_SAT_BIT] !== w.sat) begin
                    $display("%0t: residual_saturated expected %b actual %b", $realtime,
                             w.sat, m_tuser[epri_pkg::OUT_SAT_BIT]);
                    errors++;
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        if (hold > 0) begin
            m_tready <= 1'b0;
            hold <= hold - 1;
        end else if (!quiet && aresetn && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            hold <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Register write, only once every result is back and the pipe is empty.
    task automatic write_reg(input logic [epri_pkg::CFG_ADDR_BITS-1:0] idx,
                             input logic [epri_pkg::CFG_DATA_BITS-1:0] val);
        wait (verdict_q.size() == 0);
        repeat (40) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            epri_pkg::REG_ROW0:  row_reg[0] = val;
            epri_pkg::REG_ROW1:  row_reg[1] = val;
            epri_pkg::REG_ROW2:  row_reg[2] = val;
            epri_pkg::REG_LIMIT: limit_reg = val[epri_pkg::LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Drive one match on the falling edge and hold it until accepted.
    task automatic send_match(input logic [CB-1:0] lx, ly, rx, ry, input logic keep);
        int target, g;
        target = accepted + 1;
        s_tdata = {ry, rx, ly, lx};
        s_tuser = keep;
        s_tvalid = 1'b1;
        do @(negedge aclk); while (accepted != target);
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    function automatic logic [epri_pkg::CFG_DATA_BITS-1:0] pack_row(
            input logic [FB-1:0] c0, c1, c2);
        return {c2, c1, c0};
    endfunction

    // Coefficient of random magnitude, so residuals span small to saturated.
    function automatic logic [FB-1:0] rand_coef();
        logic [FB-1:0] c;
        int k;
        k = $urandom_range(0, FB - 1);
        c = FB'($urandom) & ((FB'(1) << k) - FB'(1));
        if ($urandom_range(0, 1)) c = -c;
        if ($urandom_range(0, 15) == 0) c = FB'($urandom);
        return c;
    endfunction

    match_row_t dir_rows [$];

    function automatic match_row_t mk_row(input logic [CB-1:0] lx, ly, rx, ry,
                                          input logic keep);
        match_row_t m;
        m.lx = lx; m.ly = ly; m.rx = rx; m.ry = ry; m.keep = keep;
        // With the matrix at its reset value of zero the residual is zero.
        m.typed = 1'b1;
        m.want = '{residual: '0, inlier: keep, sat: 1'b0};
        return m;
    endfunction

    task automatic walk_rows(input bit typed_ok);
        foreach (dir_rows[i]) begin
            typed_on = typed_ok && dir_rows[i].typed;
            typed_want = dir_rows[i].want;
            send_match(dir_rows[i].lx, dir_rows[i].ly, dir_rows[i].rx, dir_rows[i].ry,
                       dir_rows[i].keep);
        end
        typed_on = 1'b0;
        s_tvalid = 1'b0;
    endtask

    initial begin
        logic [FB-1:0] sc;
        logic [CB-1:0] lx, ly, rx, ry;
        int delta;
        bit rectified;
        for (int k = 0; k < 3; k++) row_reg[k] = '0;
        limit_reg = epri_pkg::LIMIT_RESET;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: coordinate extremes and both keep values after reset.
        dir_rows.insert(dir_rows.size(), mk_row('0, '0, '0, '0, 1'b1));
        dir_rows.insert(dir_rows.size(), mk_row('1, '1, '1, '1, 1'b1));
        dir_rows.insert(dir_rows.size(), mk_row('1, '0, '0, '1, 1'b0));
        dir_rows.insert(dir_rows.size(), mk_row('0, '1, '1, '0, 1'b1));
        dir_rows.insert(dir_rows.size(),
                        mk_row(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0));
        dir_rows.insert(dir_rows.size(),
                        mk_row(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE, 1'b1));
        walk_rows(1'b1);

        // Most negative coefficients everywhere: all rows but the all-zero one saturate.
        for (int k = 0; k < 3; k++)
            write_reg(epri_pkg::CFG_ADDR_BITS'(int'(epri_pkg::REG_ROW0) + k),
                      pack_row(FB'(1) << (FB-1), FB'(1) << (FB-1), FB'(1) << (FB-1)));
        write_reg(epri_pkg::REG_LIMIT, '1);
        walk_rows(1'b0);

        // Zero epipolar line: only the last row is set, so a0=a1=0 and the guard
        // term alone forms the left denominator.
        write_reg(epri_pkg::REG_ROW0, '0);
        write_reg(epri_pkg::REG_ROW1, '0);
        write_reg(epri_pkg::REG_ROW2, pack_row(FB'(3), {1'b0, {(FB-1){1'b1}}}, FB'(1)));
        write_reg(epri_pkg::REG_LIMIT, '0);
        walk_rows(1'b0);

        // Random phases: rectified pairs with near-equal rows, and random matrices.
        for (int ph = 0; ph < 8; ph++) begin
            rectified = (ph % 2 == 0);
            quiet = (ph == 3);
            if (rectified) begin
                sc = FB'($urandom_range(1, 1 << (FB - 2)));
                if ($urandom_range(0, 1)) sc = -sc;
                write_reg(epri_pkg::REG_ROW0, '0);
                write_reg(epri_pkg::REG_ROW1, pack_row('0, '0, -sc));
                write_reg(epri_pkg::REG_ROW2, pack_row('0, sc, '0));
            end else begin
                for (int k = 0; k < 3; k++)
                    write_reg(epri_pkg::CFG_ADDR_BITS'(int'(epri_pkg::REG_ROW0) + k),
                              pack_row(rand_coef(), rand_coef(), rand_coef()));
            end
            case (ph)
                0: write_reg(epri_pkg::REG_LIMIT,
                             epri_pkg::CFG_DATA_BITS'(epri_pkg::LIMIT_RESET));
                1: write_reg(epri_pkg::REG_LIMIT, '1);
                2: write_reg(epri_pkg::REG_LIMIT, '0);
                default: write_reg(epri_pkg::REG_LIMIT,
                                   epri_pkg::CFG_DATA_BITS'($urandom_range(0, 4096)));
            endcase
            for (int n = 0; n < 250; n++) begin
                lx = CB'($urandom);
                ly = CB'($urandom);
                rx = CB'($urandom);
                ry = CB'($urandom);
                if (rectified && $urandom_range(0, 9) < 8) begin
                    delta = $urandom_range(0, 80) - 40;
                    ry = ly + CB'(delta);
                end
                // Once, hold the sender until every result is back.
                if (ph == 5 && n == 125) begin
                    s_tvalid = 1'b0;
                    wait (verdict_q.size() == 0);
                    @(negedge aclk);
                end
                send_match(lx, ly, rx, ry, 1'($urandom));
            end
            s_tvalid = 1'b0;
        end

        wait (verdict_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
